FILE: rtl/core/pagq_pkg.sv
// Package: shared types and constants for the pixel gamma quantiser.
package pagq_pkg;
  localparam int unsigned SPP_W   = 16;
  localparam int unsigned MEAN_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CHAN_N  = 3;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    ST_DIV  = 3'b001,
    ST_SQRT = 3'b010,
    ST_OUT  = 3'b100
  } be_state_e;
endpackage

FILE: rtl/core/pixel_average_gamma_quantize.sv
// Top level: pixel sum average, gamma 2.0 square root and 8-bit quantiser.
//  channel | dir | tdata fields (low bit up)               | tuser
//  s_axis  | in  | sum_red, sum_green, sum_blue (SUM_WIDTH) | -
//  m_axis  | out | byte_red, byte_green, byte_blue (8 each) | -
//  cfg     | in  | samples_per_pixel (16), 0 reads as 1     | -
// Steps: SUM_WIDTH(+up-shift) divider steps, 8 root steps, output load; the
// bit-serial divider runs three per-channel lanes in step; the back end only
// starts a pixel once the last is loaded. A two-beat queue lets the front accept
// while the back works; the result register holds under m_axis stall.
// Reset: async active low, sets samples_per_pixel to 1 and empties all stages.
module pixel_average_gamma_quantize import pagq_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 32,
  parameter int unsigned SUM_FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [SPP_W-1:0] cfg_wdata_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [((3*SUM_WIDTH+7)/8)*8-1:0] s_axis_tdata, // red, green, blue sums
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [23:0] m_axis_tdata // byte_red, byte_green, byte_blue
);
  localparam int unsigned SW = SUM_WIDTH + ((SUM_FRACTION_BITS <= 16) ? 16 - SUM_FRACTION_BITS : 0);

  logic [SPP_W-1:0] spp_q;
  logic q_valid, q_pop;
  logic [3*SW-1:0] q_sums;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spp_q <= SPP_W'(1);
    else if (cfg_we_i) spp_q <= cfg_wdata_i;
  end

  pagq_front #(.SUM_WIDTH(SUM_WIDTH), .SUM_FRACTION_BITS(SUM_FRACTION_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_sums_i(s_axis_tdata[3*SUM_WIDTH-1:0]),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_sums_o(q_sums)
  );

  pagq_back #(.SW(SW)) u_back (
    .clk_i, .rst_ni, .spp_i(spp_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_sums_i(q_sums),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(m_axis_tdata)
  );
endmodule

FILE: rtl/core/pagq_front.sv
// Front end: accepts beats, scales sums to 16 fraction bits, two-entry queue.
module pagq_front import pagq_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 32,
  parameter int unsigned SUM_FRACTION_BITS = 16,
  localparam int unsigned SW = SUM_WIDTH + ((SUM_FRACTION_BITS <= 16) ? 16 - SUM_FRACTION_BITS : 0)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3*SUM_WIDTH-1:0] in_sums_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output logic [3*SW-1:0]     q_sums_o
);
  localparam int unsigned UP = (SUM_FRACTION_BITS <= 16) ? 16 - SUM_FRACTION_BITS : 0;
  localparam int unsigned DN = (SUM_FRACTION_BITS > 16) ? SUM_FRACTION_BITS - 16 : 0;

  logic [3*SW-1:0] mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wp_q, rp_q;
  logic [3*SW-1:0] sc;
  logic push, pop;

  always_comb begin
    sc = '0;
    for (int c = 0; c < 3; c++) begin
      sc[c*SW +: SW] = (SW'(in_sums_i[c*SUM_WIDTH +: SUM_WIDTH]) << UP) >> DN;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_sums_o = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= sc;
  end
endmodule

FILE: rtl/core/pagq_back.sv
// Back end: serial restoring division, serial square root, output register.
module pagq_back import pagq_pkg::*; #(
  parameter int unsigned SW = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SPP_W-1:0]  spp_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  logic [3*SW-1:0]   q_sums_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [3*BYTE_W-1:0] res_o
);
  localparam int unsigned CW = $clog2(SW + 1);

  be_state_e st_q;
  logic busy_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] quo_q [3];
  logic [SPP_W-1:0] rem_q [3];
  logic [SPP_W-1:0] div_q;
  logic [2:0] sb_q;
  logic [BYTE_W-1:0] root_q [3];
  logic [3*BYTE_W-1:0] out_q;
  logic out_v_q;
  logic out_load;
  logic [SPP_W:0] rs [3];
  logic [2*BYTE_W-1:0] sq [3];
  logic [BYTE_W-1:0] tr [3];
  logic ovf [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rs[c] = {rem_q[c], quo_q[c][SW-1]};
      tr[c] = root_q[c] | (BYTE_W'(1) << sb_q);
      sq[c] = {{BYTE_W{1'b0}}, tr[c]} * {{BYTE_W{1'b0}}, tr[c]};
      ovf[c] = (SW > MEAN_W) ? (quo_q[c] >> MEAN_W) != '0 : 1'b0;
    end
  end

  assign q_pop_o = !busy_q && q_valid_i;
  assign res_valid_o = out_v_q;
  assign res_o = out_q;
  // result register loads when the root is done and the previous beat has left or is being taken
  assign out_load = busy_q && (st_q == ST_OUT) && (!out_v_q || res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (res_valid_o && res_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_DIV;
      busy_q <= 1'b0;
      cnt_q <= '0;
      sb_q <= '0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        st_q <= ST_DIV;
        cnt_q <= CW'(SW);
        div_q <= (spp_i == '0) ? SPP_W'(1) : spp_i;
        for (int c = 0; c < 3; c++) begin
          quo_q[c] <= q_sums_i[c*SW +: SW];
          rem_q[c] <= '0;
        end
      end else if (busy_q) begin
        case (st_q)
          ST_DIV: begin
            for (int c = 0; c < 3; c++) begin
              if (rs[c] >= {1'b0, div_q}) begin
                rem_q[c] <= SPP_W'(rs[c] - {1'b0, div_q});
                quo_q[c] <= {quo_q[c][SW-2:0], 1'b1};
              end else begin
                rem_q[c] <= rs[c][SPP_W-1:0];
                quo_q[c] <= {quo_q[c][SW-2:0], 1'b0};
              end
            end
            cnt_q <= cnt_q - CW'(1);
            if (cnt_q == CW'(1)) begin
              st_q <= ST_SQRT;
              sb_q <= 3'd7;
              for (int c = 0; c < 3; c++) root_q[c] <= '0;
            end
          end
          ST_SQRT: begin
            for (int c = 0; c < 3; c++) begin
              if (ovf[c]) root_q[c] <= BYTE_MAX;
              else if (sq[c] <= quo_q[c][MEAN_W-1:0]) root_q[c] <= tr[c];
            end
            sb_q <= sb_q - 3'd1;
            if (sb_q == 3'd0) st_q <= ST_OUT;
          end
          ST_OUT: begin
            if (out_load) begin
              out_q <= {root_q[2], root_q[1], root_q[0]};
              busy_q <= 1'b0;
              st_q <= ST_DIV;
            end
          end
          default: st_q <= ST_DIV;
        endcase
      end
    end
  end
endmodule

FILE: rtl/core/pagq_checker.sv
// Checker: port-level properties of the quantiser, bound to the top level.
module pagq_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("valid during reset");
  a_nofast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!m_axis_tvalid))
    else $error("bad valid edge");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid}))
    else $error("unknown handshake level");
endmodule

bind pixel_average_gamma_quantize pagq_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
